// File: rtl/core/ps_pkg.sv
package ps_pkg;

    // width of the held value and of every candidate
    localparam int WIDTH = 32;

    // divisor width: covers the square root of any candidate plus one step
    localparam int DIV_W = (WIDTH + 1) / 2 + 1;
    // width of the running square of the divisor
    localparam int SQ_W  = 2 * DIV_W;
    // bit counter of the restoring divider
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [WIDTH-1:0] VALUE_MAX = {WIDTH{1'b1}};

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_UP    = 2'd1;
    localparam logic [1:0] REQ_DOWN  = 2'd2;
    // spare code, ignored by the block
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_PRIME = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    // command to the primality tester
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] value;
    } pt_cmd_t;

    // answer from the primality tester
    typedef struct packed {
        logic done;
        logic prime;
    } pt_res_t;

endpackage

// File: rtl/core/ps_channels.sv
interface ps_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] load_value;
    logic        return_old;

    modport source (output valid, output req_type, output load_value, output return_old,
                    input ready);
    modport sink   (input valid, input req_type, input load_value, input return_old,
                    output ready);
endinterface

interface ps_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic [31:0] current_value;
    logic [1:0]  status;

    modport source (output valid, output result_value, output current_value, output status,
                    input ready);
    modport sink   (input valid, input result_value, input current_value, input status,
                    output ready);
endinterface

// File: rtl/core/ps_prime_test.sv
module ps_prime_test
(
    input  logic            clk,
    input  logic            rst_n,
    input  ps_pkg::pt_cmd_t cmd,
    output ps_pkg::pt_res_t res
);

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_CHECK = 4'b0010,
        T_DIV   = 4'b0100,
        T_EVAL  = 4'b1000
    } t_state_t;

    t_state_t                      state_reg, state_next;
    ps_pkg::pt_res_t               res_reg, res_next;
    logic [ps_pkg::WIDTH-1:0]      n_reg, n_next;
    logic [ps_pkg::WIDTH-1:0]      shift_reg, shift_next;
    logic [ps_pkg::DIV_W-1:0]      d_reg, d_next;
    logic [ps_pkg::SQ_W-1:0]       sq_reg, sq_next;
    logic [ps_pkg::DIV_W-1:0]      rem_reg, rem_next;
    logic [ps_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                          alt_reg, alt_next;

    logic [ps_pkg::DIV_W:0]        trial;
    logic [ps_pkg::DIV_W:0]        diff;

    // one restoring step of the shared divider
    assign trial = {rem_reg, shift_reg[ps_pkg::WIDTH-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        res_next   = '0;
        n_next     = n_reg;
        shift_next = shift_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        alt_next   = alt_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (cmd.start)
                begin
                    n_next = cmd.value;
                    if (cmd.value <= ps_pkg::WIDTH'(1))
                    begin
                        res_next = '{done: 1'b1, prime: 1'b0};
                    end
                    else if (cmd.value == ps_pkg::WIDTH'(2) || cmd.value == ps_pkg::WIDTH'(3))
                    begin
                        res_next = '{done: 1'b1, prime: 1'b1};
                    end
                    else if (!cmd.value[0])
                    begin
                        res_next = '{done: 1'b1, prime: 1'b0};
                    end
                    else
                    begin
                        d_next     = ps_pkg::DIV_W'(3);
                        sq_next    = ps_pkg::SQ_W'(9);
                        alt_next   = 1'b0;
                        state_next = T_CHECK;
                    end
                end
            end
            T_CHECK:
            begin
                if (sq_reg > ps_pkg::SQ_W'(n_reg))
                begin
                    res_next   = '{done: 1'b1, prime: 1'b1};
                    state_next = T_IDLE;
                end
                else
                begin
                    shift_next = n_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = T_DIV;
                end
            end
            T_DIV:
            begin
                rem_next   = diff[ps_pkg::DIV_W] ? trial[ps_pkg::DIV_W-1:0]
                                                 : diff[ps_pkg::DIV_W-1:0];
                shift_next = {shift_reg[ps_pkg::WIDTH-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == ps_pkg::CNT_W'(ps_pkg::WIDTH - 1))
                begin
                    state_next = T_EVAL;
                end
            end
            T_EVAL:
            begin
                if (rem_reg == '0)
                begin
                    res_next   = '{done: 1'b1, prime: 1'b0};
                    state_next = T_IDLE;
                end
                else
                begin
                    // divisors run 3, 5, 7, 11, 13, 17, 19 ...
                    if (d_reg == ps_pkg::DIV_W'(3) || alt_reg)
                    begin
                        d_next   = d_reg + ps_pkg::DIV_W'(2);
                        sq_next  = sq_reg + (ps_pkg::SQ_W'(d_reg) << 2)
                                   + ps_pkg::SQ_W'(4);
                        alt_next = (d_reg == ps_pkg::DIV_W'(3));
                    end
                    else
                    begin
                        d_next   = d_reg + ps_pkg::DIV_W'(4);
                        sq_next  = sq_reg + (ps_pkg::SQ_W'(d_reg) << 3)
                                   + ps_pkg::SQ_W'(16);
                        alt_next = 1'b1;
                    end
                    state_next = T_CHECK;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        shift_reg <= shift_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        alt_reg   <= alt_next;
    end

    assign res = res_reg;

endmodule

// File: rtl/core/prime_stepper.sv
// prime_stepper holds one value, reset to 1, and moves it between primes: a load
// request stores load_value if it is prime (else 1, status 1), a step-up request
// goes to the next larger prime (value kept and status 2 if none fits), and a
// step-down request goes to the next smaller prime, never below 1. one request
// is in flight at a time and req.ready stays low while it is worked on. each
// candidate is tested by trial division by 3 and the 6k-1/6k+1 divisors up to its
// square root; every divisor goes through the one shared restoring divider
// (32 bits, one quotient bit per cycle). a finished result sits in the output
// register, so the next request may be taken while the previous response still
// waits
module prime_stepper
(
    input  logic        clk,
    input  logic        rst_n,
    ps_req_if.sink      req,
    ps_rsp_if.source    rsp
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_START  = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [ps_pkg::WIDTH-1:0] held_value_reg, held_value_next;

    // request context
    logic [1:0]               type_reg, type_next;
    logic                     ret_old_reg, ret_old_next;
    logic [ps_pkg::WIDTH-1:0] old_reg, old_next;
    logic [ps_pkg::WIDTH-1:0] cand_reg, cand_next;
    logic [ps_pkg::WIDTH-1:0] new_reg, new_next;
    logic [1:0]               st_reg, st_next;

    // output register
    logic                     rsp_valid_reg, rsp_valid_next;
    logic [31:0]              rsp_result_reg, rsp_result_next;
    logic [31:0]              rsp_current_reg, rsp_current_next;
    logic [1:0]               rsp_status_reg, rsp_status_next;

    ps_pkg::pt_cmd_t          pt_cmd;
    ps_pkg::pt_res_t          pt_res;
    logic                     accept;
    logic                     out_free;

    ps_prime_test u_test
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pt_cmd),
        .res   (pt_res)
    );

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign pt_cmd.start = (state_reg == S_START);
    assign pt_cmd.value = cand_reg;

    always_comb
    begin
        state_next       = state_reg;
        held_value_next  = held_value_reg;
        type_next        = type_reg;
        ret_old_next     = ret_old_reg;
        old_next         = old_reg;
        cand_next        = cand_reg;
        new_next         = new_reg;
        st_next          = st_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_result_next  = rsp_result_reg;
        rsp_current_next = rsp_current_reg;
        rsp_status_next  = rsp_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    type_next    = req.req_type;
                    ret_old_next = req.return_old;
                    old_next     = held_value_reg;
                    new_next     = held_value_reg;
                    st_next      = ps_pkg::ST_OK;
                    case (req.req_type)
                        ps_pkg::REQ_LOAD:
                        begin
                            // bits above WIDTH are dropped
                            cand_next  = req.load_value[ps_pkg::WIDTH-1:0];
                            state_next = S_START;
                        end
                        ps_pkg::REQ_UP:
                        begin
                            if (held_value_reg == ps_pkg::VALUE_MAX)
                            begin
                                st_next    = ps_pkg::ST_OVERFLOW;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                cand_next  = held_value_reg + 1'b1;
                                state_next = S_START;
                            end
                        end
                        ps_pkg::REQ_DOWN:
                        begin
                            if (held_value_reg <= ps_pkg::WIDTH'(2))
                            begin
                                // floor at one
                                new_next   = ps_pkg::WIDTH'(1);
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                cand_next  = held_value_reg - 1'b1;
                                state_next = S_START;
                            end
                        end
                        default:
                        begin
                            // unused code: value kept, nothing to search
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (pt_res.done)
                begin
                    if (pt_res.prime)
                    begin
                        new_next   = cand_reg;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        case (type_reg)
                            ps_pkg::REQ_LOAD:
                            begin
                                new_next   = ps_pkg::WIDTH'(1);
                                st_next    = ps_pkg::ST_NOT_PRIME;
                                state_next = S_FINISH;
                            end
                            ps_pkg::REQ_UP:
                            begin
                                if (cand_reg == ps_pkg::VALUE_MAX)
                                begin
                                    st_next    = ps_pkg::ST_OVERFLOW;
                                    state_next = S_FINISH;
                                end
                                else
                                begin
                                    cand_next  = cand_reg + 1'b1;
                                    state_next = S_START;
                                end
                            end
                            default:
                            begin
                                // stepping down always meets 2 before the floor
                                cand_next  = cand_reg - 1'b1;
                                state_next = S_START;
                            end
                        endcase
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    held_value_next  = new_reg;
                    rsp_valid_next   = 1'b1;
                    rsp_result_next  = (ret_old_reg && type_reg != ps_pkg::REQ_SPARE)
                                       ? 32'(old_reg) : 32'(new_reg);
                    rsp_current_next = 32'(new_reg);
                    rsp_status_next  = st_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_value_reg <= ps_pkg::WIDTH'(1);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_value_reg <= held_value_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg        <= type_next;
        ret_old_reg     <= ret_old_next;
        old_reg         <= old_next;
        cand_reg        <= cand_next;
        new_reg         <= new_next;
        st_reg          <= st_next;
        rsp_result_reg  <= rsp_result_next;
        rsp_current_reg <= rsp_current_next;
        rsp_status_reg  <= rsp_status_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.result_value  = rsp_result_reg;
    assign rsp.current_value = rsp_current_reg;
    assign rsp.status        = rsp_status_reg;

    // held value is 1 or a prime, never zero
    a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        held_value_reg != '0)
        else $error("held value became zero");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // a failed load always leaves 1 behind
    a_not_prime_one: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ps_pkg::ST_NOT_PRIME |-> rsp.current_value == 32'd1)
        else $error("not-prime status without value 1");

    // one request at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while another is in flight");

    // tester is only started when it is free
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pt_cmd.start |=> !pt_res.done || $past(state_reg) == S_START)
        else $error("tester answered out of turn");

endmodule

// File: bench/prime_stepper_checker.sv
`timescale 1ns / 1ps

module prime_stepper_checker
(
    input  logic clk,
    input  logic rst_n,
    ps_req_if    req_mon,
    ps_rsp_if    rsp_mon,
    output int   error_count,
    output int   outstanding,
    output int   responses_checked,
    output int   not_prime_seen,
    output int   overflow_seen
);

    typedef struct packed {
        logic [31:0] result_value;
        logic [31:0] current_value;
        logic [1:0]  status;
    } prime_answer_t;

    logic [ps_pkg::WIDTH-1:0] prime_held;
    prime_answer_t            answers_due[$];
    int                       fails;
    int                       checked;
    int                       not_prime_n;
    int                       overflow_n;

    function automatic bit is_prime_u32(logic [31:0] n);
        longint unsigned wide_n;
        longint unsigned d;
        wide_n = n;
        if (n <= 32'd1)
            return 1'b0;
        if (n == 32'd2 || n == 32'd3)
            return 1'b1;
        if (wide_n % 2 == 0 || wide_n % 3 == 0)
            return 1'b0;
        for (d = 5; d * d <= wide_n; d += 6)
        begin
            if (wide_n % d == 0 || wide_n % (d + 2) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // advances the held value for one request and returns its answer
    function automatic prime_answer_t step_prime(logic [1:0] kind, logic [31:0] load,
                                                 logic ret_old);
        prime_answer_t            ans;
        logic [ps_pkg::WIDTH-1:0] prior;
        logic [ps_pkg::WIDTH-1:0] cand;
        logic [ps_pkg::WIDTH:0]   up_probe;
        logic [ps_pkg::WIDTH-1:0] down_probe;
        bit                       applied;
        prior      = prime_held;
        cand       = load[ps_pkg::WIDTH-1:0];
        ans.status = ps_pkg::ST_OK;
        applied    = 1'b1;
        case (kind)
            ps_pkg::REQ_LOAD:
            begin
                if (is_prime_u32(32'(cand)))
                    prime_held = cand;
                else
                begin
                    prime_held = 1;
                    ans.status = ps_pkg::ST_NOT_PRIME;
                end
            end
            ps_pkg::REQ_UP:
            begin
                up_probe = {1'b0, prior} + 1'b1;
                while (!up_probe[ps_pkg::WIDTH] &&
                       !is_prime_u32(32'(up_probe[ps_pkg::WIDTH-1:0])))
                    up_probe = up_probe + 1'b1;
                if (up_probe[ps_pkg::WIDTH])
                    ans.status = ps_pkg::ST_OVERFLOW;
                else
                    prime_held = up_probe[ps_pkg::WIDTH-1:0];
            end
            ps_pkg::REQ_DOWN:
            begin
                prime_held = 1;
                if (prior > 2)
                begin
                    // 2 is prime, so the search always ends
                    down_probe = prior - 1'b1;
                    while (!is_prime_u32(32'(down_probe)))
                        down_probe = down_probe - 1'b1;
                    prime_held = down_probe;
                end
            end
            default:
                applied = 1'b0;
        endcase
        ans.current_value = 32'(prime_held);
        ans.result_value  = (ret_old && applied) ? 32'(prior) : 32'(prime_held);
        return ans;
    endfunction

    task automatic report_mismatch(input string msg);
        begin
            fails++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_response();
        prime_answer_t want;
        begin
            checked++;
            if (rsp_mon.status == ps_pkg::ST_NOT_PRIME)
                not_prime_n++;
            if (rsp_mon.status == ps_pkg::ST_OVERFLOW)
                overflow_n++;
            if (answers_due.size() == 0)
                report_mismatch($sformatf("response %0d with no request waiting", checked));
            else
            begin
                want = answers_due.pop_front();
                if (rsp_mon.result_value !== want.result_value)
                    report_mismatch($sformatf("response %0d result_value %h, expected %h",
                                              checked, rsp_mon.result_value,
                                              want.result_value));
                if (rsp_mon.current_value !== want.current_value)
                    report_mismatch($sformatf("response %0d current_value %h, expected %h",
                                              checked, rsp_mon.current_value,
                                              want.current_value));
                if (rsp_mon.status !== want.status)
                    report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                              checked, rsp_mon.status, want.status));
            end
        end
    endtask

    // responses are checked before the request of the same edge is queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_held = 1;
            answers_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_mon.valid && rsp_mon.ready)
                check_response();
            if (req_mon.valid && req_mon.ready)
                answers_due.push_back(step_prime(req_mon.req_type, req_mon.load_value,
                                                 req_mon.return_old));
            outstanding       <= answers_due.size();
            error_count       <= fails;
            responses_checked <= checked;
            not_prime_seen    <= not_prime_n;
            overflow_seen     <= overflow_n;
        end
    end

endmodule

// File: bench/prime_stepper_tb.sv
`timescale 1ns / 1ps

module prime_stepper_tb;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 10;
    // a load of the largest prime is the slowest request
    localparam int STALL_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 78;
    // requests per idling phase
    localparam int PHASE_LEN    = 40;
    localparam int DRAIN_CYCLES = 40;

    // largest prime that fits in 32 bits
    localparam logic [31:0] LARGEST_PRIME = 32'd4294967291;

    logic clk;
    logic rst_n;

    ps_req_if req_ch ();
    ps_rsp_if rsp_ch ();

    int error_count;
    int outstanding;
    int responses_checked;
    int not_prime_seen;
    int overflow_seen;

    int items_sent;
    int kind_count [4];
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;

    prime_stepper DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    prime_stepper_checker u_prime_check
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_mon           (req_ch),
        .rsp_mon           (rsp_ch),
        .error_count       (error_count),
        .outstanding       (outstanding),
        .responses_checked (responses_checked),
        .not_prime_seen    (not_prime_seen),
        .overflow_seen     (overflow_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // response side: ready drops at random according to the current phase
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog: ends the run if no request and no response moves for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d responses pending",
                     $realtime, quiet_cycles, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // sends one request; the sender may idle first, valid stays high when it does not
    task automatic issue_request(input logic [1:0] kind, input logic [31:0] value,
                                 input logic ret_old);
        begin
            // idling phases: receiver slow first, then sender slow, then neither
            case (items_sent / PHASE_LEN)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while ($urandom_range(99) < send_idle_pct)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
            req_ch.valid      <= 1'b1;
            req_ch.req_type   <= kind;
            req_ch.load_value <= value;
            req_ch.return_old <= ret_old;
            do
                @(posedge clk);
            while (!req_ch.ready);
            items_sent++;
            kind_count[kind]++;
        end
    endtask

    initial
    begin
        int          pick;
        logic [31:0] junk;

        send_idle_pct = 36;
        recv_idle_pct = 56;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= ps_pkg::REQ_LOAD;
        req_ch.load_value <= '0;
        req_ch.return_old <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: walk the small primes, with the floor at 1 on the way down
        issue_request(ps_pkg::REQ_DOWN, 32'h0, 1'b0);
        issue_request(ps_pkg::REQ_UP,   32'hFFFF_FFFF, 1'b1);
        issue_request(ps_pkg::REQ_UP,   32'h0, 1'b0);
        issue_request(ps_pkg::REQ_UP,   32'h0, 1'b0);
        issue_request(ps_pkg::REQ_DOWN, 32'h0, 1'b1);
        issue_request(ps_pkg::REQ_DOWN, 32'h0, 1'b0);
        issue_request(ps_pkg::REQ_DOWN, 32'h0, 1'b0);
        // loads of the values that are not prime by definition, then the first primes
        issue_request(ps_pkg::REQ_LOAD, 32'd0, 1'b0);
        issue_request(ps_pkg::REQ_LOAD, 32'd1, 1'b1);
        issue_request(ps_pkg::REQ_LOAD, 32'd2, 1'b0);
        issue_request(ps_pkg::REQ_LOAD, 32'd3, 1'b1);
        issue_request(ps_pkg::REQ_LOAD, 32'd97, 1'b0);
        // spare code keeps the value and ignores return_old
        issue_request(ps_pkg::REQ_SPARE, 32'hFFFF_FFFF, 1'b1);
        issue_request(ps_pkg::REQ_DOWN, 32'h0, 1'b1);
        // composite odd value, all ones, all ones but bit 0
        issue_request(ps_pkg::REQ_LOAD, 32'd91, 1'b1);
        issue_request(ps_pkg::REQ_LOAD, 32'hFFFF_FFFF, 1'b0);
        issue_request(ps_pkg::REQ_LOAD, 32'hFFFF_FFFE, 1'b0);
        // top of the range: nothing larger fits, so the step up overflows
        issue_request(ps_pkg::REQ_LOAD, LARGEST_PRIME, 1'b1);
        issue_request(ps_pkg::REQ_SPARE, 32'h0, 1'b0);
        issue_request(ps_pkg::REQ_UP, 32'h0, 1'b1);
        issue_request(ps_pkg::REQ_LOAD, 32'd13, 1'b0);
        issue_request(ps_pkg::REQ_UP, 32'h0, 1'b1);

        // random: loads stay small so the searches stay short, wide loads are even
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            junk = $urandom();
            if (pick < 25)
                issue_request(ps_pkg::REQ_LOAD, $urandom_range(600), 1'($urandom_range(1)));
            else if (pick < 35)
                issue_request(ps_pkg::REQ_LOAD, junk & 32'hFFFF_FFFE, 1'($urandom_range(1)));
            else if (pick < 65)
                issue_request(ps_pkg::REQ_UP, junk, 1'($urandom_range(1)));
            else if (pick < 95)
                issue_request(ps_pkg::REQ_DOWN, junk, 1'($urandom_range(1)));
            else
                issue_request(ps_pkg::REQ_SPARE, junk, 1'($urandom_range(1)));
        end
        req_ch.valid <= 1'b0;

        // checker counts are registered outputs of the checker
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests: %0d loads, %0d steps up, %0d steps down, %0d spare",
                 items_sent, kind_count[ps_pkg::REQ_LOAD], kind_count[ps_pkg::REQ_UP],
                 kind_count[ps_pkg::REQ_DOWN], kind_count[ps_pkg::REQ_SPARE]);
        $display("%0d responses compared, %0d rejected loads, %0d overflowing steps",
                 responses_checked, not_prime_seen, overflow_seen);
        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
